@@ src/dtcfs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dtcfs_pkg;

  localparam int CFG_COLS_W  = 7;
  localparam int CFG_ROWS_W  = 6;
  localparam int CFG_DATA_W  = 7;
  localparam int ROW_IDX_W   = 8;
  localparam int COL_IDX_W   = 6;
  localparam int OUT_ROW_W   = 5;
  localparam int GLYPH_W     = 8;
  localparam int SCAN_ROW_W  = 5;
  localparam int REQ_W       = 2;
  localparam int KIND_W      = 3;
  localparam int OUT_DATA_W  = 24;

  localparam logic [GLYPH_W-1:0] BLANK_GLYPH = 8'd32;
  // Depth offset of 1100 in fixed point with 8 fraction bits.
  localparam int DEPTH_OFFSET = 1100 * 256;

  typedef enum logic [REQ_W-1:0] {
    REQ_PLOT  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_SCAN  = 2'd2
  } req_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_DRAWN     = 3'd0,
    KIND_HIDDEN    = 3'd1,
    KIND_OUTSIDE   = 3'd2,
    KIND_CLEARED   = 3'd3,
    KIND_CHANGED   = 3'd4,
    KIND_UNCHANGED = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    OP_PLOT_IN,
    OP_PLOT_OUT,
    OP_CLEAR,
    OP_SCAN,
    OP_SCAN_NONE
  } op_e;

  typedef enum logic [0:0] {
    CFG_COLUMNS = 1'b0,
    CFG_ROWS    = 1'b1
  } cfg_idx_e;

  // Classified request as it travels from the front end to the back end.
  typedef struct packed {
    op_e                  op;
    logic [ROW_IDX_W-1:0] row;
    logic [COL_IDX_W-1:0] col;
    logic [GLYPH_W-1:0]   glyph;
    logic                 key_pos;
  } cmd_t;

  typedef struct packed {
    kind_e                kind;
    logic [OUT_ROW_W-1:0] row;
    logic [COL_IDX_W-1:0] col;
    logic [GLYPH_W-1:0]   glyph;
    logic                 last;
  } res_t;

  // Depth key width: room for z plus the offset, with a sign bit.
  function automatic int key_width(int coord_bits);
    return ((coord_bits > 20) ? coord_bits : 20) + 1;
  endfunction

endpackage

`default_nettype wire

@@ src/dtcfs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dtcfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ src/dtcfs_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dtcfs_queue #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ src/dtcfs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dtcfs_front #(
  parameter int COORD_BITS = 24,
  parameter int IN_W       = ((3 * COORD_BITS + 13 + 7) / 8) * 8,
  parameter int KEY_W      = dtcfs_pkg::key_width(COORD_BITS)
) (
  input  wire logic                              item_valid_i,
  output logic                                   item_ready_o,
  input  wire logic [IN_W-1:0]                   item_data_i,
  input  wire logic [dtcfs_pkg::REQ_W-1:0]       item_type_i,
  input  wire logic [dtcfs_pkg::CFG_COLS_W-1:0]  w_eff_i,
  input  wire logic [dtcfs_pkg::CFG_ROWS_W-1:0]  h_eff_i,
  input  wire logic                              init_busy_i,
  input  wire logic                              q_full_i,
  output logic                                   q_push_o,
  output dtcfs_pkg::cmd_t                        cmd_o,
  output logic      [KEY_W-1:0]                  key_o
);

  import dtcfs_pkg::*;

  localparam int CW = COORD_BITS + 2;
  localparam logic signed [CW-1:0] MINUS_256 = CW'(-256);

  logic signed [COORD_BITS-1:0] x_s, y_s, z_s;
  logic [GLYPH_W-1:0]           glyph;
  logic [SCAN_ROW_W-1:0]        scan_row;
  logic signed [CW-1:0]         vx, vy;
  logic                         col_ok, row_ok;
  logic                         accept;

  assign x_s      = $signed(item_data_i[COORD_BITS-1:0]);
  assign y_s      = $signed(item_data_i[2*COORD_BITS-1:COORD_BITS]);
  assign z_s      = $signed(item_data_i[3*COORD_BITS-1:2*COORD_BITS]);
  assign glyph    = item_data_i[3*COORD_BITS+GLYPH_W-1:3*COORD_BITS];
  assign scan_row = item_data_i[3*COORD_BITS+GLYPH_W+SCAN_ROW_W-1:3*COORD_BITS+GLYPH_W];

  // Mapped coordinates in fixed point; the cell index is the integer part.
  assign vx = (CW'(x_s) <<< 1) + CW'(int'(w_eff_i) * 128);
  assign vy = CW'(y_s) + CW'(int'(h_eff_i) * 128);

  // A negative value above -1.0 truncates toward zero and lands in cell zero.
  assign col_ok = vx[CW-1] ? (vx > MINUS_256) : (vx[CW-1:8] < (CW-8)'(w_eff_i));
  assign row_ok = vy[CW-1] ? (vy > MINUS_256) : (vy[CW-1:8] < (CW-8)'(h_eff_i));

  assign key_o        = KEY_W'(z_s) + KEY_W'(DEPTH_OFFSET);
  assign item_ready_o = !q_full_i && !init_busy_i;
  assign accept       = item_valid_i && item_ready_o;

  always_comb begin
    cmd_o.op      = OP_CLEAR;
    cmd_o.row     = vy[CW-1] ? '0 : vy[15:8];
    cmd_o.col     = vx[CW-1] ? '0 : vx[13:8];
    cmd_o.glyph   = glyph;
    cmd_o.key_pos = !key_o[KEY_W-1] && (key_o != '0);
    q_push_o      = 1'b0;
    case (item_type_i)
      REQ_PLOT: begin
        cmd_o.op = (col_ok && row_ok) ? OP_PLOT_IN : OP_PLOT_OUT;
        q_push_o = accept;
      end
      REQ_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        q_push_o = accept;
      end
      REQ_SCAN: begin
        cmd_o.op  = ({1'b0, scan_row} < h_eff_i) ? OP_SCAN : OP_SCAN_NONE;
        cmd_o.row = ROW_IDX_W'(scan_row);
        q_push_o  = accept;
      end
      default: begin
        // Unused request code: taken and dropped.
        q_push_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/dtcfs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dtcfs_back #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 32,
  parameter int COORD_BITS  = 24,
  parameter int KEY_W       = dtcfs_pkg::key_width(COORD_BITS)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cmd_valid_i,
  output logic                                   cmd_ready_o,
  input  wire dtcfs_pkg::cmd_t                   cmd_i,
  input  wire logic [KEY_W-1:0]                  key_i,
  input  wire logic [dtcfs_pkg::CFG_COLS_W-1:0]  w_eff_i,
  output logic                                   init_busy_o,
  output logic                                   res_valid_o,
  input  wire logic                              res_ready_i,
  output dtcfs_pkg::res_t                        res_o
);

  import dtcfs_pkg::*;

  localparam int CELLS  = MAX_COLUMNS * MAX_ROWS;
  localparam int AW     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int WORD_W = 1 + KEY_W + GLYPH_W;
  localparam logic [WORD_W-1:0] BLANK_WORD = {1'b0, {KEY_W{1'b0}}, BLANK_GLYPH};

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PLOT,
    ST_CLEAR,
    ST_SCAN,
    ST_SCAN_END
  } state_e;

  state_e                  state_q, state_d;
  logic [AW-1:0]           cnt_q, cnt_d;
  logic [CFG_COLS_W-1:0]   col_q, col_d, col_next;
  cmd_t                    cmd_q, cmd_d;
  logic [KEY_W-1:0]        key_q, key_d;
  res_t                    res_q, res_d;
  logic                    res_vld_q, res_vld_d;
  res_t                    pend_q, pend_d;
  logic                    pend_vld_q, pend_vld_d;

  logic                    cell_we, cell_re;
  logic [AW-1:0]           cell_waddr, rd_addr;
  logic [WORD_W-1:0]       cell_wdata, cell_rdata;
  logic                    shown_we;
  logic [AW-1:0]           shown_waddr;
  logic [GLYPH_W-1:0]      shown_wdata, shown_rdata;

  logic                    out_free;
  logic                    stored_vld;
  logic [KEY_W-1:0]        stored_key;
  logic [GLYPH_W-1:0]      stored_glyph;
  logic                    draw, diff;

  function automatic logic [AW-1:0] cell_addr(logic [ROW_IDX_W-1:0] row,
                                              logic [CFG_COLS_W-1:0] col);
    return AW'(int'(row) * MAX_COLUMNS + int'(col));
  endfunction

  dtcfs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .re_i    (cell_re),
    .raddr_i (rd_addr),
    .rdata_o (cell_rdata)
  );

  dtcfs_ram #(
    .WIDTH (GLYPH_W),
    .DEPTH (CELLS)
  ) u_shown_ram (
    .clk_i   (clk_i),
    .we_i    (shown_we),
    .waddr_i (shown_waddr),
    .wdata_i (shown_wdata),
    .re_i    (cell_re),
    .raddr_i (rd_addr),
    .rdata_o (shown_rdata)
  );

  assign stored_vld   = cell_rdata[WORD_W-1];
  assign stored_key   = cell_rdata[KEY_W+GLYPH_W-1:GLYPH_W];
  assign stored_glyph = cell_rdata[GLYPH_W-1:0];
  assign draw         = cmd_q.key_pos && (!stored_vld || (key_q < stored_key));
  assign diff         = (stored_glyph != shown_rdata);
  assign col_next     = col_q + CFG_COLS_W'(1);
  assign out_free     = !res_vld_q || res_ready_i;

  assign init_busy_o  = (state_q == ST_INIT);
  assign res_valid_o  = res_vld_q;
  assign res_o        = res_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    col_d       = col_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    res_d       = res_q;
    res_vld_d   = res_vld_q && !res_ready_i;
    pend_d      = pend_q;
    pend_vld_d  = pend_vld_q;
    cmd_ready_o = 1'b0;
    cell_we     = 1'b0;
    cell_waddr  = cnt_q;
    cell_wdata  = BLANK_WORD;
    cell_re     = 1'b0;
    rd_addr     = cell_addr(cmd_i.row, CFG_COLS_W'(cmd_i.col));
    shown_we    = 1'b0;
    shown_waddr = cnt_q;
    shown_wdata = BLANK_GLYPH;

    case (state_q)
      ST_INIT: begin
        // Blank both frames and empty the depth store after reset.
        cell_we  = 1'b1;
        shown_we = 1'b1;
        cnt_d    = cnt_q + AW'(1);
        if (cnt_q == AW'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o = 1'b1;
          cmd_d       = cmd_i;
          key_d       = key_i;
          case (cmd_i.op)
            OP_PLOT_IN: begin
              cell_re = 1'b1;
              state_d = ST_PLOT;
            end
            OP_PLOT_OUT: begin
              res_d     = '{kind: KIND_OUTSIDE, row: '0, col: '0, glyph: '0, last: 1'b1};
              res_vld_d = 1'b1;
            end
            OP_CLEAR: begin
              cnt_d   = '0;
              state_d = ST_CLEAR;
            end
            OP_SCAN: begin
              rd_addr    = cell_addr(cmd_i.row, '0);
              cell_re    = 1'b1;
              col_d      = '0;
              pend_vld_d = 1'b0;
              state_d    = ST_SCAN;
            end
            OP_SCAN_NONE: begin
              res_d     = '{kind: KIND_UNCHANGED, row: cmd_i.row[OUT_ROW_W-1:0],
                            col: '0, glyph: '0, last: 1'b1};
              res_vld_d = 1'b1;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_PLOT: begin
        cell_waddr = cell_addr(cmd_q.row, CFG_COLS_W'(cmd_q.col));
        cell_wdata = {1'b1, key_q, cmd_q.glyph};
        cell_we    = draw;
        res_d      = '{kind: draw ? KIND_DRAWN : KIND_HIDDEN,
                       row: cmd_q.row[OUT_ROW_W-1:0], col: cmd_q.col,
                       glyph: draw ? cmd_q.glyph : stored_glyph, last: 1'b1};
        res_vld_d  = 1'b1;
        state_d    = ST_IDLE;
      end

      ST_CLEAR: begin
        cell_we = 1'b1;
        cnt_d   = cnt_q + AW'(1);
        if (cnt_q == AW'(CELLS - 1)) begin
          res_d     = '{kind: KIND_CLEARED, row: '0, col: '0, glyph: '0, last: 1'b1};
          res_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // A changed cell is held back one step so that the final one can carry last.
        if (!(diff && pend_vld_q && !out_free)) begin
          if (diff) begin
            shown_we    = 1'b1;
            shown_waddr = cell_addr(cmd_q.row, col_q);
            shown_wdata = stored_glyph;
            if (pend_vld_q) begin
              res_d     = pend_q;
              res_vld_d = 1'b1;
            end
            pend_d     = '{kind: KIND_CHANGED, row: cmd_q.row[OUT_ROW_W-1:0],
                           col: col_q[COL_IDX_W-1:0], glyph: stored_glyph, last: 1'b0};
            pend_vld_d = 1'b1;
          end
          if (col_next < w_eff_i) begin
            col_d   = col_next;
            rd_addr = cell_addr(cmd_q.row, col_next);
            cell_re = 1'b1;
          end else begin
            state_d = ST_SCAN_END;
          end
        end
      end

      ST_SCAN_END: begin
        if (out_free) begin
          if (pend_vld_q) begin
            res_d      = pend_q;
            res_d.last = 1'b1;
          end else begin
            res_d = '{kind: KIND_UNCHANGED, row: cmd_q.row[OUT_ROW_W-1:0],
                      col: '0, glyph: '0, last: 1'b1};
          end
          res_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      cnt_q      <= '0;
      col_q      <= '0;
      cmd_q      <= '0;
      key_q      <= '0;
      res_q      <= '0;
      res_vld_q  <= 1'b0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      col_q      <= col_d;
      cmd_q      <= cmd_d;
      key_q      <= key_d;
      res_q      <= res_d;
      res_vld_q  <= res_vld_d;
      pend_q     <= pend_d;
      pend_vld_q <= pend_vld_d;
    end
  end

endmodule

`default_nettype wire

@@ src/depth_tested_char_frame_store_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Character frame store with depth test and differential row scan-out.
// Requests arrive on the s_axis channel, one transfer each: a plot of a point, a clear of
// the whole frame, or a scan of one row. Results leave on m_axis; tlast marks the final
// result of a request, and tuser carries the result kind. Frame width and height are set
// through the write port, by the user only while idle; the block does not enforce this.
// A front end classifies each request (cell mapping, bounds check, depth key) and places
// it in a two-entry queue; a back end reads and updates the frame memories.
// In the back end a plot inside the frame reads the memory, then tests and writes, taking
// no new request meanwhile; its result is registered after the queue and memory read,
// while a point outside skips the read. A clear walks all MAX_COLUMNS * MAX_ROWS cells,
// one per cycle. A row scan reads one column per cycle across the frame width while the
// output is not stalled, and emits one transfer per changed cell, or one unchanged result
// if none changed. After reset the back end blanks the frames and empties the depth store
// over all MAX_COLUMNS * MAX_ROWS cells (2048 by default); s_axis_tready stays low until
// that is done. When the receiver stalls, the finished result is held in the output
// register; the queue keeps taking requests until it is full, then s_axis_tready drops.
module depth_tested_char_frame_store_core #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 32,
  parameter int COORD_BITS  = 24,
  parameter int IN_W        = ((3 * COORD_BITS + 13 + 7) / 8) * 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // point_x, point_y, point_z, glyph, scan_row, then zero padding
  input  wire logic [IN_W-1:0]                   s_axis_tdata,
  // req_type
  input  wire logic [dtcfs_pkg::REQ_W-1:0]       s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // cell_row, cell_col, cell_glyph, then zero padding
  output logic      [dtcfs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // kind
  output logic      [dtcfs_pkg::KIND_W-1:0]      m_axis_tuser,
  output logic                                   m_axis_tlast,
  input  wire logic                              cfg_we_i,
  input  wire logic [0:0]                        cfg_idx_i,
  input  wire logic [dtcfs_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import dtcfs_pkg::*;

  localparam int KEY_W = key_width(COORD_BITS);
  localparam int Q_W   = KEY_W + $bits(cmd_t);

  logic [CFG_COLS_W-1:0] cols_q;
  logic [CFG_ROWS_W-1:0] rows_q;
  logic [CFG_COLS_W-1:0] w_eff;
  logic [CFG_ROWS_W-1:0] h_eff;

  logic                  init_busy;
  logic                  q_push, q_full, q_pop, q_valid;
  cmd_t                  front_cmd, back_cmd;
  logic [KEY_W-1:0]      front_key, back_key;
  logic [Q_W-1:0]        q_head;
  res_t                  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= CFG_COLS_W'(64);
      rows_q <= CFG_ROWS_W'(32);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLUMNS: cols_q <= cfg_data_i;
        CFG_ROWS:    rows_q <= cfg_data_i[CFG_ROWS_W-1:0];
        default:     cols_q <= cols_q;
      endcase
    end
  end

  // Zero acts as one; values beyond the store act as its maximum.
  always_comb begin
    if (cols_q == '0) begin
      w_eff = CFG_COLS_W'(1);
    end else if (int'(cols_q) > MAX_COLUMNS) begin
      w_eff = CFG_COLS_W'(MAX_COLUMNS);
    end else begin
      w_eff = cols_q;
    end
    if (rows_q == '0) begin
      h_eff = CFG_ROWS_W'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      h_eff = CFG_ROWS_W'(MAX_ROWS);
    end else begin
      h_eff = rows_q;
    end
  end

  dtcfs_front #(
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W),
    .KEY_W      (KEY_W)
  ) u_front (
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_data_i  (s_axis_tdata),
    .item_type_i  (s_axis_tuser),
    .w_eff_i      (w_eff),
    .h_eff_i      (h_eff),
    .init_busy_i  (init_busy),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .cmd_o        (front_cmd),
    .key_o        (front_key)
  );

  dtcfs_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i ({front_key, front_cmd}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_head)
  );

  assign back_cmd = q_head[$bits(cmd_t)-1:0];
  assign back_key = q_head[Q_W-1:$bits(cmd_t)];

  dtcfs_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .COORD_BITS  (COORD_BITS),
    .KEY_W       (KEY_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_pop),
    .cmd_i       (back_cmd),
    .key_i       (back_key),
    .w_eff_i     (w_eff),
    .init_busy_o (init_busy),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {5'd0, res.glyph, res.col, res.row};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

  // No result may appear while the memories are still being blanked.
  a_no_result_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> !m_axis_tvalid)
    else $error("result presented during the reset clearing pass");

  // The front end must never push into a full queue.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("request pushed into a full queue");

  // The back end takes a new request only when the output register frees up.
  a_pop_with_free_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (!m_axis_tvalid || m_axis_tready))
    else $error("request taken while a result is stalled");

  // A popped request always comes from a non-empty queue.
  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

@@ tb/tb_depth_tested_char_frame_store_core.sv @@
`timescale 1ns / 1ps

module tb_depth_tested_char_frame_store_core;
  import dtcfs_pkg::*;

  localparam int FRAME_COLS   = 64;
  localparam int FRAME_ROWS   = 32;
  localparam int FRAME_CELLS  = FRAME_COLS * FRAME_ROWS;
  localparam int COORD_W      = 24;
  localparam int IN_W         = 88;
  localparam int COL_LSB      = OUT_ROW_W;
  localparam int GLYPH_LSB    = OUT_ROW_W + COL_IDX_W;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  // A clear walks every cell once, so the block can be busy that long with no transfer.
  localparam int SETTLE_CYCLES = FRAME_CELLS + 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 10000;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata  = '0;
  logic [REQ_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]     m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_we_i      = 1'b0;
  logic [0:0]            cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  depth_tested_char_frame_store_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow copy of the frame store.
  logic [GLYPH_W-1:0] frame_glyphs [FRAME_CELLS];
  logic [GLYPH_W-1:0] shown_copy   [FRAME_CELLS];
  longint             depth_key    [FRAME_CELLS];
  logic               depth_set    [FRAME_CELLS];
  logic [CFG_COLS_W-1:0] cols_reg = 7'd64;
  logic [CFG_ROWS_W-1:0] rows_reg = 6'd32;

  res_t due_reports [$];

  int send_idle_pct = 23;
  int recv_idle_pct = 79;
  bit hold_toggle   = 1'b0;
  bit hold_ack      = 1'b0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int mismatches    = 0;
  int reports_seen  = 0;
  int requests_sent = 0;
  int clears_sent   = 0;
  int scans_sent    = 0;
  int sizes_tried   = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int cols_active();
    if (cols_reg == 0) return 1;
    if (cols_reg > FRAME_COLS) return FRAME_COLS;
    return int'(cols_reg);
  endfunction

  function automatic int rows_active();
    if (rows_reg == 0) return 1;
    if (rows_reg > FRAME_ROWS) return FRAME_ROWS;
    return int'(rows_reg);
  endfunction

  function automatic void blank_frame(input bit also_shown);
    for (int i = 0; i < FRAME_CELLS; i++) begin
      frame_glyphs[i] = BLANK_GLYPH;
      depth_key[i]    = 0;
      depth_set[i]    = 1'b0;
      if (also_shown) shown_copy[i] = BLANK_GLYPH;
    end
  endfunction

  function automatic res_t make_report(input kind_e kind, input int row, input int col,
                                       input logic [GLYPH_W-1:0] glyph, input logic last);
    res_t r;
    r.kind  = kind;
    r.row   = row[OUT_ROW_W-1:0];
    r.col   = col[COL_IDX_W-1:0];
    r.glyph = glyph;
    r.last  = last;
    return r;
  endfunction

  // Applies one accepted request to the shadow store and queues the reports it causes.
  function automatic void track_request(input logic [REQ_W-1:0] req,
                                        input logic signed [COORD_W-1:0] px, py, pz,
                                        input logic [GLYPH_W-1:0] glyph,
                                        input logic [SCAN_ROW_W-1:0] srow);
    int     w;
    int     h;
    longint col;
    longint row;
    longint key;
    int     idx;
    int     n;
    res_t   r;
    w = cols_active();
    h = rows_active();
    case (req)
      REQ_PLOT: begin
        // Integer division truncates toward zero, as the cell mapping requires.
        col = (2 * longint'(px) + w * 128) / 256;
        row = (longint'(py) + h * 128) / 256;
        key = longint'(pz) + DEPTH_OFFSET;
        if (col < 0 || col >= w || row < 0 || row >= h) begin
          due_reports.push_back(make_report(KIND_OUTSIDE, 0, 0, '0, 1'b1));
        end else begin
          idx = int'(row) * FRAME_COLS + int'(col);
          if (key > 0 && (!depth_set[idx] || key < depth_key[idx])) begin
            frame_glyphs[idx] = glyph;
            depth_key[idx]    = key;
            depth_set[idx]    = 1'b1;
            due_reports.push_back(make_report(KIND_DRAWN, int'(row), int'(col), glyph, 1'b1));
          end else begin
            due_reports.push_back(make_report(KIND_HIDDEN, int'(row), int'(col),
                                              frame_glyphs[idx], 1'b1));
          end
        end
      end
      REQ_CLEAR: begin
        blank_frame(1'b0);
        due_reports.push_back(make_report(KIND_CLEARED, 0, 0, '0, 1'b1));
        clears_sent++;
      end
      REQ_SCAN: begin
        n = 0;
        if (int'(srow) < h) begin
          for (int c = 0; c < w; c++) begin
            idx = int'(srow) * FRAME_COLS + c;
            if (frame_glyphs[idx] != shown_copy[idx]) begin
              shown_copy[idx] = frame_glyphs[idx];
              due_reports.push_back(make_report(KIND_CHANGED, int'(srow), c,
                                                frame_glyphs[idx], 1'b0));
              n++;
            end
          end
        end
        if (n == 0) begin
          due_reports.push_back(make_report(KIND_UNCHANGED, int'(srow), 0, '0, 1'b1));
        end else begin
          r = due_reports.pop_back();
          r.last = 1'b1;
          due_reports.push_back(r);
        end
        scans_sent++;
      end
      default: ;
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off whenever the test flips hold_toggle.
  always @(posedge clk_i) begin
    if (hold_toggle != hold_ack) begin
      hold_ack      <= hold_toggle;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      reports_seen++;
      if (due_reports.size() == 0) begin
        $error("unexpected result: kind %0d, data %h", m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = due_reports.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[COL_LSB-1:0] !== want.row) begin
          $error("cell_row: expected %0d, got %0d", want.row, m_axis_tdata[COL_LSB-1:0]);
          mismatches++;
        end
        if (m_axis_tdata[GLYPH_LSB-1:COL_LSB] !== want.col) begin
          $error("cell_col: expected %0d, got %0d", want.col,
                 m_axis_tdata[GLYPH_LSB-1:COL_LSB]);
          mismatches++;
        end
        if (m_axis_tdata[GLYPH_LSB+GLYPH_W-1:GLYPH_LSB] !== want.glyph) begin
          $error("cell_glyph: expected %0d, got %0d", want.glyph,
                 m_axis_tdata[GLYPH_LSB+GLYPH_W-1:GLYPH_LSB]);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // Ends the run if nothing moves for far longer than a clear or a hold-off takes.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Leaves tvalid high after a transfer so that back-to-back requests need no extra edge.
  task automatic send_request(input logic [REQ_W-1:0] req,
                              input logic signed [COORD_W-1:0] px, py, pz,
                              input logic [GLYPH_W-1:0] glyph,
                              input logic [SCAN_ROW_W-1:0] srow);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {3'b000, srow, glyph, pz, py, px};
    // Ready only changes just after a rising edge, so it is sampled in mid-cycle to see
    // the value that the next edge will use.
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    track_request(req, px, py, pz, glyph, srow);
    if (req != REQ_UNUSED) requests_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_frame_size(input logic [CFG_DATA_W-1:0] cols,
                                input logic [CFG_DATA_W-1:0] rows);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_COLUMNS;
    cfg_data_i <= cols;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ROWS;
    cfg_data_i <= rows;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cols_reg = cols;
    rows_reg = rows[CFG_ROWS_W-1:0];
    sizes_tried++;
  endtask

  function automatic logic [COORD_W-1:0] any_coord();
    return $urandom;
  endfunction

  // Mostly keys in a narrow band, with some at or behind the eye plane and some repeated.
  function automatic logic [COORD_W-1:0] pick_depth();
    int sel;
    sel = $urandom_range(7);
    case (sel)
      0:       return -DEPTH_OFFSET - int'($urandom_range(1000));
      1, 2:    return 256 * int'($urandom_range(3));
      default: return int'($urandom_range(600000)) - 300000;
    endcase
  endfunction

  // A point that lands in or just around the current frame.
  task automatic plot_near_frame();
    int w;
    int h;
    w = cols_active();
    h = rows_active();
    send_request(REQ_PLOT, int'($urandom_range(w * 128 + 512)) - (w * 64 + 256),
                 int'($urandom_range(h * 256 + 512)) - (h * 128 + 256),
                 pick_depth(), $urandom, $urandom);
  endtask

  task automatic random_request();
    int sel;
    int h;
    sel = $urandom_range(99);
    h   = rows_active();
    if (sel < 2) begin
      send_request(REQ_CLEAR, any_coord(), any_coord(), any_coord(), $urandom, $urandom);
    end else if (sel < 4) begin
      send_request(REQ_UNUSED, any_coord(), any_coord(), any_coord(), $urandom, $urandom);
    end else if (sel < 18) begin
      send_request(REQ_SCAN, any_coord(), any_coord(), any_coord(), $urandom,
                   ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(h - 1));
    end else if (sel < 27) begin
      send_request(REQ_PLOT, any_coord(), any_coord(), any_coord(), $urandom, $urandom);
    end else begin
      plot_near_frame();
    end
  endtask

  task automatic run_random_requests(input int count);
    int target;
    target = requests_sent + count;
    while (requests_sent < target) random_request();
  endtask

  // Default 64 x 32 frame: the center cell maps to row 16, column 32.
  task automatic test_plot_cases();
    send_request(REQ_PLOT, 0, 0, 0, "A", 0);
    send_request(REQ_PLOT, 0, 0, 0, "B", 0);            // equal key stays hidden
    send_request(REQ_PLOT, 0, 0, -256, "C", 0);         // nearer point wins
    send_request(REQ_PLOT, 0, 0, 256, "D", 0);
    send_request(REQ_PLOT, 256, 0, -DEPTH_OFFSET, "E", 0);  // key of zero, empty cell
    send_request(REQ_PLOT, 256, 0, -24'sd8388608, "F", 31);
    send_request(REQ_PLOT, 256, 0, 24'sd8388607, "G", 0);
    send_request(REQ_PLOT, 24'sd8388607, 0, 0, "H", 0);
    send_request(REQ_PLOT, -24'sd8388608, 0, 0, "I", 0);
    send_request(REQ_PLOT, 0, 24'sd8388607, 0, "J", 0);
    send_request(REQ_PLOT, 0, -24'sd8388608, 0, "K", 0);
    // Mapped values just below zero truncate to cell zero; a full step below is outside.
    send_request(REQ_PLOT, -4146, -4196, 0, 8'h00, 0);
    send_request(REQ_PLOT, -4224, 0, 0, "L", 0);
    send_request(REQ_PLOT, 0, -4352, 0, "M", 0);
    send_request(REQ_PLOT, 4095, 4095, 0, 8'hff, 5'd31);
    send_request(REQ_PLOT, 4096, 0, 0, "N", 0);
    send_request(REQ_PLOT, 0, 4096, 0, "O", 0);
    send_request(REQ_UNUSED, 0, 0, 0, "P", 0);
  endtask

  task automatic test_clear_and_scan();
    send_request(REQ_SCAN, 0, 0, 0, 0, 5'd16);
    send_request(REQ_SCAN, 0, 0, 0, 0, 5'd16);
    send_request(REQ_SCAN, 0, 0, 0, 0, 5'd0);
    send_request(REQ_CLEAR, 0, 0, 0, 0, 0);
    send_request(REQ_SCAN, 0, 0, 0, 0, 5'd31);
    send_request(REQ_SCAN, 0, 0, 0, 0, 5'd5);
    send_request(REQ_PLOT, 0, 0, 24'sd8388607, "Q", 0);
  endtask

  task automatic test_frame_sizes();
    int size_cols [6] = '{1, 0, 127, 64, 10, 33};
    int size_rows [6] = '{1, 0, 63, 32, 5, 17};
    for (int i = 0; i < 6; i++) begin
      set_frame_size(size_cols[i], size_rows[i]);
      repeat (4) plot_near_frame();
      send_request(REQ_SCAN, any_coord(), any_coord(), any_coord(), $urandom, 5'd31);
      send_request(REQ_SCAN, any_coord(), any_coord(), any_coord(), $urandom,
                   $urandom_range(rows_active() - 1));
    end
  endtask

  // The receiver holds off while plots keep coming, so the input side has to stall.
  task automatic test_backpressure();
    send_idle_pct = 0;
    hold_toggle   = ~hold_toggle;
    repeat (16) plot_near_frame();
    send_request(REQ_SCAN, 0, 0, 0, 0, $urandom_range(rows_active() - 1));
    wait_drained();
    send_idle_pct = 23;
  endtask

  task automatic test_random_traffic();
    set_frame_size($urandom_range(1, 24), $urandom_range(1, 12));
    run_random_requests(65);
    set_frame_size($urandom_range(1, 24), $urandom_range(1, 12));
    send_idle_pct = 79;
    recv_idle_pct = 23;
    run_random_requests(65);
    set_frame_size($urandom_range(127), $urandom_range(63));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_requests(65);
  endtask

  initial begin
    blank_frame(1'b1);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_plot_cases();
    test_clear_and_scan();
    test_frame_sizes();
    test_backpressure();
    test_random_traffic();
    settle();
    $display("Sent %0d requests (%0d clears, %0d row scans) over %0d frame sizes.",
             requests_sent, clears_sent, scans_sent, sizes_tried + 1);
    $display("Checked %0d results with %0d mismatches.", reports_seen, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/dtcfs_pkg.sv
src/dtcfs_ram.sv
src/dtcfs_queue.sv
src/dtcfs_front.sv
src/dtcfs_back.sv
src/depth_tested_char_frame_store_core.sv
tb/tb_depth_tested_char_frame_store_core.sv
